// File: hw/rtl/sle_pkg.sv
// sle_pkg: request and status codes, field widths and the control/status
// structs shared by the sorted list controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int DATA_W  = 32;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request, set up pointer and early status
    logic prime;  // issue first store read
    logic step;   // one walk step over the store
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;     // request settled at set-up, no store access needed
    logic is_read;  // read-at: one read, then answer
    logic last;     // current walk step ends the request
  } dp_stat_t;

endpackage

// File: hw/rtl/sorted_list_engine.sv
// sorted_list_engine: top level of the bounded ascending integer list.
// Depends on sle_pkg, sle_ctrl (sequencer) and sle_dp (store and datapath).
`timescale 1ns / 1ps
//
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------
//  request   start / busy       in_req_type, in_operand
//  result    out_valid strobe   out_status, out_read_value, out_entry_count
//
// An item is taken when start is high and busy is low; its one result is
// shown for a single cycle with out_valid, busy still high, and busy drops
// at the end of that cycle.
// A refused request or a read-at goes from prime straight to respond; any
// other request walks the entry store (one read port, one write port) in
// between. Insert takes one step per entry moved up plus a closing step,
// remove takes fill + 1 steps and pop-first takes fill steps.
// Synchronous active-low reset empties the list; store contents are not
// cleared, as only entries below the fill count are ever used.
// The result side cannot stall, so no output buffering is needed.

module sorted_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [sle_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [sle_pkg::DATA_W-1:0]  in_operand,
  output logic                               out_valid,
  output logic [sle_pkg::ST_W-1:0]           out_status,
  output logic signed [sle_pkg::DATA_W-1:0]  out_read_value,
  output logic [sle_pkg::COUNT_W-1:0]        out_entry_count
);

  // command and status between sequencer and datapath
  sle_pkg::ctrl_cmd_t cmd;
  sle_pkg::dp_stat_t  stat;

  // sequencer: idle -> prime -> walk -> respond
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // store, fill count and walk pointer; results are held in registers
  // and stay steady through the response cycle
  sle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_operand      (in_operand),
    .res_status      (out_status),
    .res_read_value  (out_read_value),
    .res_entry_count (out_entry_count)
  );

endmodule

// File: hw/rtl/sle_ctrl.sv
// sle_ctrl: request sequencer for the sorted list engine.
// Depends on sle_pkg (command/status structs).
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output sle_pkg::ctrl_cmd_t cmd,
  input  sle_pkg::dp_stat_t  stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        if (stat.skip) begin
          state_nxt = S_RESP;
        end else begin
          cmd.prime = 1'b1;
          state_nxt = stat.is_read ? S_RESP : S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.last) state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

// File: hw/rtl/sle_dp.sv
// sle_dp: entry store, fill count, walk pointer and result registers.
// Depends on sle_pkg (codes, widths, command/status structs).
`timescale 1ns / 1ps

module sle_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sle_pkg::ctrl_cmd_t                  cmd,
  output sle_pkg::dp_stat_t                   stat,
  input  logic [sle_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [sle_pkg::DATA_W-1:0]   in_operand,
  output logic [sle_pkg::ST_W-1:0]            res_status,
  output logic signed [sle_pkg::DATA_W-1:0]   res_read_value,
  output logic [sle_pkg::COUNT_W-1:0]         res_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [sle_pkg::DATA_W-1:0] mem [CAPACITY];
  logic signed [sle_pkg::DATA_W-1:0] rdata_r;

  logic [sle_pkg::REQ_W-1:0]          req_r;
  logic signed [sle_pkg::DATA_W-1:0]  opv_r;
  logic [CW-1:0]                      ptr_r, ptr_nxt;
  logic [CW-1:0]                      fill_r, fill_nxt;
  logic                               found_r, found_nxt;
  logic                               skip_r, skip_nxt;
  logic [sle_pkg::ST_W-1:0]           status_r, status_nxt;

  logic                               rd_en, wr_en;
  logic [CW-1:0]                      rd_ptr, wr_ptr;
  logic signed [sle_pkg::DATA_W-1:0]  wr_data;
  logic                               last;

  always_comb begin
    ptr_nxt    = ptr_r;
    fill_nxt   = fill_r;
    found_nxt  = found_r;
    skip_nxt   = skip_r;
    status_nxt = status_r;
    rd_en      = 1'b0;
    rd_ptr     = ptr_r;
    wr_en      = 1'b0;
    wr_ptr     = ptr_r;
    wr_data    = opv_r;
    last       = 1'b0;

    if (cmd.load) begin
      found_nxt  = (in_req_type == sle_pkg::REQ_POP);
      status_nxt = sle_pkg::ST_OK;
      case (in_req_type)
        sle_pkg::REQ_INSERT: begin
          ptr_nxt  = fill_r;
          skip_nxt = (fill_r >= CW'(CAPACITY));
          if (skip_nxt) status_nxt = sle_pkg::ST_FULL;
        end
        sle_pkg::REQ_REMOVE: begin
          ptr_nxt  = '0;
          skip_nxt = (fill_r == '0);
          if (skip_nxt) status_nxt = sle_pkg::ST_NOT_FOUND;
        end
        sle_pkg::REQ_READ: begin
          // negative position reads the head
          if (in_operand < 0) begin
            ptr_nxt  = '0;
            skip_nxt = (fill_r == '0);
          end else begin
            ptr_nxt  = in_operand[CW-1:0];
            skip_nxt = ($unsigned(in_operand) >= sle_pkg::DATA_W'(fill_r));
          end
          if (skip_nxt) status_nxt = sle_pkg::ST_EMPTY;
        end
        default: begin  // pop first: start shifting from position one
          ptr_nxt  = CW'(1);
          skip_nxt = (fill_r == '0);
          if (skip_nxt) status_nxt = sle_pkg::ST_EMPTY;
        end
      endcase
    end

    if (cmd.prime) begin
      if (req_r == sle_pkg::REQ_INSERT) begin
        rd_ptr = ptr_r - 1'b1;
        rd_en  = (ptr_r != '0);
      end else begin
        rd_ptr = ptr_r;
        rd_en  = (ptr_r < CW'(CAPACITY));
      end
    end

    if (cmd.step) begin
      if (req_r == sle_pkg::REQ_INSERT) begin
        // walk down from the top, moving entries >= value up by one
        if (ptr_r == '0) begin
          wr_en    = 1'b1;
          last     = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end else if (rdata_r >= opv_r) begin
          wr_en   = 1'b1;
          wr_data = rdata_r;
          ptr_nxt = ptr_r - 1'b1;
          rd_ptr  = ptr_r - CW'(2);
          rd_en   = (ptr_r >= CW'(2));
        end else begin
          wr_en    = 1'b1;
          last     = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end else begin
        // remove / pop: find the entry, then close the gap
        if (ptr_r == fill_r) begin
          last = 1'b1;
          if (found_r) begin
            fill_nxt   = fill_r - 1'b1;
            status_nxt = sle_pkg::ST_OK;
          end else begin
            status_nxt = sle_pkg::ST_NOT_FOUND;
          end
        end else begin
          if (found_r) begin
            wr_en   = 1'b1;
            wr_ptr  = ptr_r - 1'b1;
            wr_data = rdata_r;
          end else if (rdata_r == opv_r) begin
            found_nxt = 1'b1;
          end
          ptr_nxt = ptr_r + 1'b1;
          rd_ptr  = ptr_r + 1'b1;
          rd_en   = ((ptr_r + 1'b1) < CW'(CAPACITY)) && (ptr_r != CW'(CAPACITY));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(wr_ptr)] <= wr_data;
    if (rd_en) rdata_r <= mem[AW'(rd_ptr)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      opv_r <= in_operand;
    end
    ptr_r    <= ptr_nxt;
    found_r  <= found_nxt;
    skip_r   <= skip_nxt;
    status_r <= status_nxt;
  end

  assign stat.skip    = skip_r;
  assign stat.is_read = (req_r == sle_pkg::REQ_READ);
  assign stat.last    = last;

  assign res_status      = status_r;
  assign res_read_value  = ((req_r == sle_pkg::REQ_READ) && (status_r == sle_pkg::ST_OK))
                           ? rdata_r : '0;
  assign res_entry_count = sle_pkg::COUNT_W'(fill_r);

endmodule
